// ===== rtl/itf_pkg.sv =====
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types, widths and constants of the IMU complementary tilt filter.
// ----------------------------------------------------------------------------
package itf_pkg;

  localparam int IN_W      = 16;
  localparam int DT_W      = 20;
  localparam int SCALE_W   = 16;
  localparam int ALPHA_W   = 17;
  localparam int ANG_W     = 17;
  localparam int RATE_W    = 19;
  localparam int P_W       = 33;
  localparam int PMAG_W    = 32;
  localparam int SUMSQ_W   = 32;
  localparam int PDT_W     = 52;
  localparam int NUM_W     = 52;
  localparam int QUOT_W    = 26;
  localparam int GA_W      = 28;
  localparam int XY_W      = 27;
  localparam int Z_W       = 25;
  localparam int RAD_W     = 48;
  localparam int ATAN_W    = 22;
  localparam int ATAN_IDX_W = 5;
  localparam int M_W       = 46;
  localparam int MIX_W     = 47;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W = 120;
  localparam int OUT_DATA_W = 96;

  localparam int unsigned DT_DEN   = 256000000;
  localparam int unsigned DT_HALF  = 128000000;
  // DT_DEN = DT_ODD * 2^DT_PRE_SH; the odd part goes by reciprocal multiply
  localparam int DT_PRE_SH   = 14;
  localparam int DT_ODD      = 15625;
  localparam int DT_RECIP_SH = 51;
  localparam int DT_RECIP_W  = 38;
  localparam logic [DT_RECIP_W-1:0] DT_RECIP =
      DT_RECIP_W'(((64'd1 << DT_RECIP_SH) + 64'(DT_ODD - 1)) / 64'(DT_ODD));
  localparam int ANG_LIMIT  = 46080;
  localparam int QUARTER    = 23040;
  localparam int RATE_MAX   = 262143;
  localparam int RATE_MIN   = -262144;
  localparam int ONE_Q16    = 65536;
  localparam int SCALE_RST  = 1998;
  localparam int ALPHA_RST  = 62915;

  localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA = 2'd1;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic start;
    logic bl1;
    logic bl2;
    logic bl3;
    logic bl4;
  } itf_cmd_t;

  typedef struct packed {
    logic units_done;
    logic out_free;
  } itf_sts_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    begin
      case (idx)
        5'd0:  v = 22'd2949120;
        5'd1:  v = 22'd1740967;
        5'd2:  v = 22'd919879;
        5'd3:  v = 22'd466945;
        5'd4:  v = 22'd234379;
        5'd5:  v = 22'd117304;
        5'd6:  v = 22'd58666;
        5'd7:  v = 22'd29335;
        5'd8:  v = 22'd14668;
        5'd9:  v = 22'd7334;
        5'd10: v = 22'd3667;
        5'd11: v = 22'd1833;
        5'd12: v = 22'd917;
        5'd13: v = 22'd458;
        5'd14: v = 22'd229;
        5'd15: v = 22'd115;
        5'd16: v = 22'd57;
        5'd17: v = 22'd29;
        5'd18: v = 22'd14;
        5'd19: v = 22'd7;
        5'd20: v = 22'd4;
        5'd21: v = 22'd2;
        5'd22: v = 22'd1;
        default: v = '0;
      endcase
      atan_lut = v;
    end
  endfunction

  // round(p / 256) half away from zero, optional negate, saturate
  function automatic logic signed [RATE_W-1:0] rate_out(input logic signed [P_W-1:0] p,
                                                         input logic neg);
    logic [P_W-1:0] mag;
    logic [P_W-1:0] q;
    logic signed [P_W:0] v;
    begin
      mag = p[P_W-1] ? P_W'(-p) : P_W'(p);
      q   = (mag + P_W'(128)) >> 8;
      v   = (p[P_W-1] ^ neg) ? -$signed({1'b0, q}) : $signed({1'b0, q});
      if (v > (P_W+1)'(RATE_MAX)) begin
        rate_out = RATE_W'(RATE_MAX);
      end else if (v < (P_W+1)'(RATE_MIN)) begin
        rate_out = RATE_W'(RATE_MIN);
      end else begin
        rate_out = RATE_W'(v);
      end
    end
  endfunction

endpackage

// ===== rtl/itf_tilt.sv =====
// ----------------------------------------------------------------------------
// itf_tilt
// Accelerometer tilt angle: bit-pair square root of the cross-axis energy,
// then CORDIC vectoring, one step per cycle. Angle in 1/256 degree.
// ----------------------------------------------------------------------------
module itf_tilt #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [itf_pkg::ANG_W-1:0]    num,
  input  logic [itf_pkg::SUMSQ_W-1:0]         sumsq,
  output logic                                done,
  output logic signed [itf_pkg::ANG_W-1:0]    angle
);

  localparam int IW = $clog2(CORDIC_ITERATIONS);
  localparam int RW = itf_pkg::RAD_W + 1;

  typedef enum logic [2:0] {T_IDLE, T_SQRT, T_CORD, T_ROUND, T_DONE} tstate_t;

  tstate_t state_r;
  tstate_t state_nxt;

  logic [itf_pkg::RAD_W-1:0]       n_r;
  logic [RW-1:0]                   res_r;
  logic [RW-1:0]                   bit_r;
  logic signed [itf_pkg::XY_W-1:0] x_r;
  logic signed [itf_pkg::XY_W-1:0] y_r;
  logic signed [itf_pkg::Z_W-1:0]  z_r;
  logic [IW-1:0]                   i_r;
  logic signed [itf_pkg::ANG_W-1:0] ang_r;

  logic [RW:0]                     trial;
  logic                            ge;
  logic signed [itf_pkg::XY_W-1:0] xs;
  logic signed [itf_pkg::XY_W-1:0] ys;
  logic signed [itf_pkg::Z_W-1:0]  at;
  logic [itf_pkg::Z_W-1:0]         zmag;
  logic [itf_pkg::Z_W-1:0]         zq;
  logic signed [itf_pkg::ANG_W-1:0] special;

  assign trial = {1'b0, res_r} + {1'b0, bit_r};
  assign ge    = {2'b00, n_r} >= trial;
  assign xs    = x_r >>> i_r;
  assign ys    = y_r >>> i_r;
  assign at    = $signed({{(itf_pkg::Z_W-itf_pkg::ATAN_W){1'b0}},
                          itf_pkg::atan_lut(itf_pkg::ATAN_IDX_W'(i_r))});
  assign zmag  = z_r[itf_pkg::Z_W-1] ? itf_pkg::Z_W'(-z_r) : itf_pkg::Z_W'(z_r);
  assign zq    = (zmag + itf_pkg::Z_W'(128)) >> 8;

  always_comb begin
    if (num == '0) begin
      special = '0;
    end else if (!num[itf_pkg::ANG_W-1]) begin
      special = itf_pkg::ANG_W'(itf_pkg::QUARTER);
    end else begin
      special = -(itf_pkg::ANG_W'(itf_pkg::QUARTER));
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_SQRT: begin
        if (bit_r == '0) begin
          state_nxt = (res_r == '0) ? T_DONE : T_CORD;
        end
      end
      T_CORD: begin
        if (i_r == IW'(CORDIC_ITERATIONS - 1)) begin
          state_nxt = T_ROUND;
        end
      end
      T_ROUND: state_nxt = T_DONE;
      default: state_nxt = state_r;
    endcase
    if (start) begin
      state_nxt = T_SQRT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= {sumsq, 16'h0000};
      res_r <= '0;
      bit_r <= RW'(1) << itf_pkg::RAD_W;
      x_r   <= '0;
      y_r   <= {{2{num[itf_pkg::ANG_W-1]}}, num, 8'h00};
      z_r   <= '0;
      i_r   <= '0;
    end else begin
      case (state_r)
        T_SQRT: begin
          if (bit_r != '0) begin
            if (ge) begin
              n_r   <= n_r - trial[itf_pkg::RAD_W-1:0];
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end else if (res_r == '0) begin
            ang_r <= special;
          end else begin
            x_r <= $signed(res_r[itf_pkg::XY_W-1:0]);
          end
        end
        T_CORD: begin
          if (y_r > 0) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + at;
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - at;
          end
          i_r <= i_r + IW'(1);
        end
        T_ROUND: begin
          ang_r <= z_r[itf_pkg::Z_W-1] ? -$signed(itf_pkg::ANG_W'(zq))
                                       : $signed(itf_pkg::ANG_W'(zq));
        end
        default: ;
      endcase
    end
  end

  assign done  = (state_r == T_DONE);
  assign angle = ang_r;

endmodule

// ===== rtl/itf_cdiv.sv =====
// ----------------------------------------------------------------------------
// itf_cdiv
// Division by the microsecond-to-degree constant: shift out the power of two,
// then reciprocal multiply in 19-bit pieces. Done rises with the new quotient.
// ----------------------------------------------------------------------------
module itf_cdiv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [itf_pkg::NUM_W-1:0]   dividend,
  output logic                        done,
  output logic [itf_pkg::QUOT_W-1:0]  quot
);

  localparam int XW = itf_pkg::NUM_W - itf_pkg::DT_PRE_SH;
  localparam int HW = XW / 2;
  localparam int PW = 2 * HW;
  localparam int SW = 2 * XW;

  localparam logic [HW-1:0] M_HI = itf_pkg::DT_RECIP[XW-1:HW];
  localparam logic [HW-1:0] M_LO = itf_pkg::DT_RECIP[HW-1:0];

  logic [1:0]                   stage_r;
  logic                         done_r;
  logic [HW-1:0]                xh_r;
  logic [HW-1:0]                xl_r;
  logic [PW-1:0]                hh_r;
  logic [PW-1:0]                hl_r;
  logic [PW-1:0]                lh_r;
  logic [PW-1:0]                ll_r;
  logic [itf_pkg::QUOT_W-1:0]   quot_r;
  logic [SW-1:0]                prod;

  assign prod = (SW'(hh_r) << PW) + (SW'(hl_r) << HW) + (SW'(lh_r) << HW) + SW'(ll_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
      done_r  <= 1'b0;
    end else if (start) begin
      stage_r <= 2'b01;
      done_r  <= 1'b0;
    end else begin
      stage_r <= {stage_r[0], 1'b0};
      if (stage_r[1]) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xh_r <= dividend[itf_pkg::NUM_W-1:itf_pkg::NUM_W-HW];
      xl_r <= dividend[itf_pkg::DT_PRE_SH+HW-1:itf_pkg::DT_PRE_SH];
    end
    if (stage_r[0]) begin
      hh_r <= xh_r * M_HI;
      hl_r <= xh_r * M_LO;
      lh_r <= xl_r * M_HI;
      ll_r <= xl_r * M_LO;
    end
    if (stage_r[1]) begin
      quot_r <= itf_pkg::QUOT_W'(prod[SW-1:itf_pkg::DT_RECIP_SH]);
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== rtl/itf_datapath.sv =====
// ----------------------------------------------------------------------------
// itf_datapath
// Config registers, rate products, per-axis tilt and integration units,
// blend arithmetic, filter state and the output register.
// ----------------------------------------------------------------------------
module itf_datapath #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  itf_pkg::itf_cmd_t                 cmd,
  output itf_pkg::itf_sts_t                 sts,
  input  logic                              cfg_we,
  input  logic [itf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [itf_pkg::ALPHA_W-1:0]       cfg_data,
  input  logic [itf_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [itf_pkg::OUT_DATA_W-1:0]    out_tdata
);

  logic [itf_pkg::SCALE_W-1:0]            scale_r;
  logic [itf_pkg::ALPHA_W-1:0]            alpha_r;
  logic [itf_pkg::ALPHA_W-1:0]            alpha_c_r;
  logic [itf_pkg::ALPHA_W-1:0]            beta_r;

  logic signed [itf_pkg::IN_W-1:0]        a_r [3];
  logic signed [itf_pkg::IN_W-1:0]        g_r [3];
  logic [itf_pkg::DT_W-1:0]               dt_r;
  logic signed [itf_pkg::P_W-1:0]         p_r [3];
  logic [itf_pkg::SUMSQ_W-1:0]            sumsq_r [2];
  logic [itf_pkg::PDT_W-1:0]              pdt_r [2];
  logic signed [itf_pkg::GA_W-1:0]        ga_r [2];
  logic signed [itf_pkg::ANG_W-1:0]       acc_r [2];
  logic signed [itf_pkg::M_W-1:0]         m1_r [2];
  logic signed [itf_pkg::M_W-1:0]         m2_r [2];
  logic signed [itf_pkg::MIX_W-1:0]       mix_r [2];
  logic signed [itf_pkg::ANG_W-1:0]       est_r [2];
  logic                                   out_valid_r;
  logic [itf_pkg::OUT_DATA_W-1:0]         out_data_r;

  logic signed [itf_pkg::SUMSQ_W-1:0]     sq [3];
  logic signed [itf_pkg::ANG_W-1:0]       num [2];
  logic [itf_pkg::PMAG_W-1:0]             pmag [2];
  logic [itf_pkg::QUOT_W-1:0]             quot [2];
  logic signed [itf_pkg::ANG_W-1:0]       ang [2];
  logic                                   tdone [2];
  logic                                   ddone [2];
  logic signed [itf_pkg::ANG_W-1:0]       est_nxt [2];
  logic signed [itf_pkg::ANG_W-1:0]       pitch_neg;

  // round(mix / 65536) half away from zero, clamp to +-180 degrees
  function automatic logic signed [itf_pkg::ANG_W-1:0] blend_fin(
      input logic signed [itf_pkg::MIX_W-1:0] mix);
    logic [itf_pkg::MIX_W-1:0] mag;
    logic [itf_pkg::MIX_W-1:0] q;
    logic [itf_pkg::ANG_W-1:0] qc;
    begin
      mag = mix[itf_pkg::MIX_W-1] ? itf_pkg::MIX_W'(-mix) : itf_pkg::MIX_W'(mix);
      q   = (mag + itf_pkg::MIX_W'(32768)) >> 16;
      qc  = (q > itf_pkg::MIX_W'(itf_pkg::ANG_LIMIT)) ? itf_pkg::ANG_W'(itf_pkg::ANG_LIMIT)
                                                      : q[itf_pkg::ANG_W-1:0];
      blend_fin = mix[itf_pkg::MIX_W-1] ? -$signed(qc) : $signed(qc);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= itf_pkg::SCALE_W'(itf_pkg::SCALE_RST);
      alpha_r <= itf_pkg::ALPHA_W'(itf_pkg::ALPHA_RST);
    end else if (cfg_we) begin
      if (cfg_index == itf_pkg::REG_GYRO_SCALE) begin
        scale_r <= cfg_data[itf_pkg::SCALE_W-1:0];
      end else if (cfg_index == itf_pkg::REG_BLEND_ALPHA) begin
        alpha_r <= cfg_data;
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    assign sq[k] = a_r[k] * a_r[k];
  end

  assign num[0]  = itf_pkg::ANG_W'(a_r[1]);
  assign num[1]  = -(itf_pkg::ANG_W'(a_r[0]));
  assign pmag[0] = p_r[0][itf_pkg::P_W-1] ? itf_pkg::PMAG_W'(-p_r[0]) : itf_pkg::PMAG_W'(p_r[0]);
  assign pmag[1] = p_r[1][itf_pkg::P_W-1] ? itf_pkg::PMAG_W'(-p_r[1]) : itf_pkg::PMAG_W'(p_r[1]);

  // lane 0: roll, lane 1: pitch
  for (genvar k = 0; k < 2; k++) begin : g_lane
    itf_tilt #(
      .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_tilt (
      .clk   (clk),
      .rst_n (rst_n),
      .start (cmd.start),
      .num   (num[k]),
      .sumsq (sumsq_r[k]),
      .done  (tdone[k]),
      .angle (ang[k])
    );

    itf_cdiv u_cdiv (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (cmd.start),
      .dividend (itf_pkg::NUM_W'(pdt_r[k]) + itf_pkg::NUM_W'(itf_pkg::DT_HALF)),
      .done     (ddone[k]),
      .quot     (quot[k])
    );

    assign est_nxt[k] = blend_fin(mix_r[k]);

    always_ff @(posedge clk) begin
      if (cmd.mul2) begin
        pdt_r[k] <= pmag[k] * dt_r;
      end
      if (cmd.bl1) begin
        ga_r[k]  <= itf_pkg::GA_W'(est_r[k]) +
                    (p_r[k][itf_pkg::P_W-1] ? -$signed({2'b00, quot[k]})
                                            : $signed({2'b00, quot[k]}));
        acc_r[k] <= ang[k];
      end
      if (cmd.bl2) begin
        m1_r[k] <= $signed({1'b0, alpha_c_r}) * ga_r[k];
        m2_r[k] <= itf_pkg::M_W'($signed({1'b0, beta_r}) * acc_r[k]);
      end
      if (cmd.bl3) begin
        mix_r[k] <= itf_pkg::MIX_W'(m1_r[k]) + itf_pkg::MIX_W'(m2_r[k]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        est_r[k] <= '0;
      end else if (cmd.bl4) begin
        est_r[k] <= est_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r[0] <= $signed(in_tdata[15:0]);
      a_r[1] <= $signed(in_tdata[31:16]);
      a_r[2] <= $signed(in_tdata[47:32]);
      g_r[0] <= $signed(in_tdata[63:48]);
      g_r[1] <= $signed(in_tdata[79:64]);
      g_r[2] <= $signed(in_tdata[95:80]);
      dt_r   <= in_tdata[115:96];
    end
    if (cmd.mul1) begin
      for (int k = 0; k < 3; k++) begin
        p_r[k] <= g_r[k] * $signed({1'b0, scale_r});
      end
      sumsq_r[0] <= $unsigned(sq[0]) + $unsigned(sq[2]);
      sumsq_r[1] <= $unsigned(sq[1]) + $unsigned(sq[2]);
      alpha_c_r  <= (alpha_r > itf_pkg::ALPHA_W'(itf_pkg::ONE_Q16))
                    ? itf_pkg::ALPHA_W'(itf_pkg::ONE_Q16) : alpha_r;
    end
    if (cmd.bl1) begin
      beta_r <= itf_pkg::ALPHA_W'(itf_pkg::ONE_Q16) - alpha_c_r;
    end
  end

  assign pitch_neg = -est_nxt[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.bl4) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bl4) begin
      out_data_r <= {5'b00000,
                     itf_pkg::rate_out(p_r[2], 1'b1),
                     itf_pkg::rate_out(p_r[1], 1'b1),
                     itf_pkg::rate_out(p_r[0], 1'b0),
                     pitch_neg,
                     est_nxt[0]};
    end
  end

  assign sts.units_done = tdone[0] & tdone[1] & ddone[0] & ddone[1];
  assign sts.out_free   = !out_valid_r;
  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_data_r;

  a_bl4_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bl4 |-> !out_valid_r)
    else $error("result written over a pending one");

  a_est_range: assert property (@(posedge clk) disable iff (!rst_n)
    (est_r[0] <= itf_pkg::ANG_W'(itf_pkg::ANG_LIMIT)) &&
    (est_r[0] >= -(itf_pkg::ANG_W'(itf_pkg::ANG_LIMIT))) &&
    (est_r[1] <= itf_pkg::ANG_W'(itf_pkg::ANG_LIMIT)) &&
    (est_r[1] >= -(itf_pkg::ANG_W'(itf_pkg::ANG_LIMIT))))
    else $error("angle estimate out of range");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !sts.units_done)
    else $error("units report done right after start");

endmodule

// ===== rtl/itf_ctrl.sv =====
// ----------------------------------------------------------------------------
// itf_ctrl
// Sequencer: products, unit launch, wait, blend steps and result write.
// ----------------------------------------------------------------------------
module itf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  itf_pkg::itf_sts_t  sts,
  output itf_pkg::itf_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_START, S_WAIT, S_BL1, S_BL2, S_BL3, S_BL4
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   ready_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_START;
      S_START: state_nxt = S_WAIT;
      S_WAIT:  if (sts.units_done) state_nxt = S_BL1;
      S_BL1:   state_nxt = S_BL2;
      S_BL2:   state_nxt = S_BL3;
      S_BL3:   if (sts.out_free) state_nxt = S_BL4;
      S_BL4:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_tready = ready_r;
  assign cmd.load  = ready_r && in_tvalid;
  assign cmd.mul1  = (state_r == S_MUL1);
  assign cmd.mul2  = (state_r == S_MUL2);
  assign cmd.start = (state_r == S_START);
  assign cmd.bl1   = (state_r == S_BL1);
  assign cmd.bl2   = (state_r == S_BL2);
  assign cmd.bl3   = (state_r == S_BL3);
  assign cmd.bl4   = (state_r == S_BL4);

endmodule

// ===== rtl/imu_complementary_tilt_filter_unit.sv =====
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_unit
// Roll/pitch complementary filter for one six-axis IMU sample per request.
// ----------------------------------------------------------------------------
// One request at a time: a sample is taken, then the products are formed and the
// units launched; the tilt units run the square root, CORDIC_ITERATIONS steps
// and a rounding step, their done is picked up, and the blend steps write the
// result. The next sample is taken in the cycle after the result is written at
// the earliest. A zero cross-axis energy skips CORDIC and rounding. The
// integration-step division runs beside the tilt units and finishes before
// them. A finished result waits in the output register while the next sample
// is taken; a second one stalls the input until the first is read.
module imu_complementary_tilt_filter_unit #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, elapsed_us
  input  logic [itf_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // roll_deg, pitch_deg, roll_rate, pitch_rate, yaw_rate
  output logic [itf_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_we,
  input  logic [itf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [itf_pkg::ALPHA_W-1:0]        cfg_data
);

  itf_pkg::itf_cmd_t cmd;
  itf_pkg::itf_sts_t sts;

  itf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  itf_datapath #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== dv/imu_complementary_tilt_filter_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_unit_tb
// Drives six-axis samples through the tilt filter and checks every result
// against a bit-exact predictor of the rates, CORDIC tilt angles and blend,
// or a row's fixed word. A directed table comes first, then random samples
// over several register settings, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module imu_complementary_tilt_filter_unit_tb;

  localparam logic [itf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS = 250;

  typedef enum logic [1:0] {CFG_NONE, CFG_BOTH, CFG_BOGUS} cfg_act_t;

  typedef struct {
    cfg_act_t act;
    logic [itf_pkg::SCALE_W-1:0] scale;
    logic [itf_pkg::ALPHA_W-1:0] alpha;
    logic signed [15:0] ax, ay, az, gx, gy, gz;
    logic [itf_pkg::DT_W-1:0] dt;
    logic typed;
    logic [itf_pkg::OUT_DATA_W-1:0] exp_word;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [itf_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [itf_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [itf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [itf_pkg::ALPHA_W-1:0] cfg_data = '0;

  logic [itf_pkg::OUT_DATA_W-1:0] expected_q[$];
  longint roll_est, pitch_est;
  longint gyro_scale_m, blend_alpha_m;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int idle_cycles = 0;
  bit long_hold = 0;
  longint atan_steps[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                             29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                             57, 29, 14, 7, 4, 2, 1, 0};

  imu_complementary_tilt_filter_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint div_round(longint num, longint den);
    longint m;
    m = (num < 0) ? -num : num;
    m = (m + den / 2) / den;
    return (num < 0) ? -m : m;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  // atan2(num, sqrt(b^2 + c^2)) in 1/256 degree
  function automatic longint tilt_angle(longint num, longint b, longint c);
    longint x, y, z, xs, ys;
    longint unsigned sumsq;
    sumsq = longint'(b * b + c * c);
    x = int_sqrt(sumsq << 16);
    y = num * 256;
    z = 0;
    if (x == 0) begin
      if (y == 0) return 0;
      return (y > 0) ? itf_pkg::QUARTER : -itf_pkg::QUARTER;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_steps[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_steps[i];
      end
    end
    return div_round(z, 256);
  endfunction

  function automatic longint blend_angle(longint est, longint p, longint dt,
                                         longint acc, longint alpha);
    longint gyro_ang, mix;
    gyro_ang = est + div_round(p * dt, longint'(itf_pkg::DT_DEN));
    mix = alpha * gyro_ang + (itf_pkg::ONE_Q16 - alpha) * acc;
    return clampl(div_round(mix, itf_pkg::ONE_Q16), -itf_pkg::ANG_LIMIT, itf_pkg::ANG_LIMIT);
  endfunction

  function automatic logic [itf_pkg::OUT_DATA_W-1:0] predict_tilt(
      logic [itf_pkg::IN_DATA_W-1:0] d);
    longint ax, ay, az, px, py, pz, dt, alpha, acc_roll, acc_pitch;
    logic [18:0] rr, pr, yr;
    logic [16:0] ro, po;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    px = longint'($signed(d[63:48])) * gyro_scale_m;
    py = longint'($signed(d[79:64])) * gyro_scale_m;
    pz = longint'($signed(d[95:80])) * gyro_scale_m;
    dt = longint'(d[115:96]);
    alpha = (blend_alpha_m > itf_pkg::ONE_Q16) ? itf_pkg::ONE_Q16 : blend_alpha_m;
    acc_roll = tilt_angle(ay, ax, az);
    acc_pitch = tilt_angle(-ax, ay, az);
    roll_est = blend_angle(roll_est, px, dt, acc_roll, alpha);
    pitch_est = blend_angle(pitch_est, py, dt, acc_pitch, alpha);
    ro = roll_est[16:0];
    po = 17'(-pitch_est);
    rr = 19'(clampl(div_round(px, 256), itf_pkg::RATE_MIN, itf_pkg::RATE_MAX));
    pr = 19'(clampl(-div_round(py, 256), itf_pkg::RATE_MIN, itf_pkg::RATE_MAX));
    yr = 19'(clampl(-div_round(pz, 256), itf_pkg::RATE_MIN, itf_pkg::RATE_MAX));
    return {5'd0, yr, pr, rr, po, ro};
  endfunction

  function automatic logic [itf_pkg::IN_DATA_W-1:0] pack_sample(
      logic [15:0] ax, ay, az, gx, gy, gz, logic [itf_pkg::DT_W-1:0] dt);
    return {4'd0, dt, gz, gy, gx, az, ay, ax};
  endfunction

  task automatic cmp_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      $error("%s mismatch: expected %0h actual %0h", name, e, a);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    logic [itf_pkg::OUT_DATA_W-1:0] e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $error("result with no request pending: %h", out_tdata);
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        cmp_field("roll_deg", 32'(e[16:0]), 32'(out_tdata[16:0]));
        cmp_field("pitch_deg", 32'(e[33:17]), 32'(out_tdata[33:17]));
        cmp_field("roll_rate", 32'(e[52:34]), 32'(out_tdata[52:34]));
        cmp_field("pitch_rate", 32'(e[71:53]), 32'(out_tdata[71:53]));
        cmp_field("yaw_rate", 32'(e[90:72]), 32'(out_tdata[90:72]));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result receiver
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 0;
      end
      g = $urandom_range(0, 99);
      if (g < 55) begin
        out_tready <= 1'b1;
      end else if (g < 95) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(20, 80)) @(negedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [itf_pkg::CFG_IDX_W-1:0] idx,
                           logic [itf_pkg::ALPHA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == itf_pkg::REG_GYRO_SCALE) gyro_scale_m = val[itf_pkg::SCALE_W-1:0];
    else if (idx == itf_pkg::REG_BLEND_ALPHA) blend_alpha_m = val;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // one request; called at a falling edge
  task automatic send_sample(logic [itf_pkg::IN_DATA_W-1:0] d, logic typed,
                             logic [itf_pkg::OUT_DATA_W-1:0] typed_word);
    logic [itf_pkg::OUT_DATA_W-1:0] p;
    int g;
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = predict_tilt(d);
    expected_q.push_back(typed ? typed_word : p);
    n_sent++;
    @(negedge clk);
    g = $urandom_range(0, 99);
    if (g >= 60) begin
      in_tvalid <= 1'b0;
      repeat ((g < 96) ? $urandom_range(1, 5) : $urandom_range(30, 120)) @(negedge clk);
    end
  endtask

  function automatic logic [15:0] rand_axis(int mode);
    case (mode)
      0: return 16'd0;
      1: return 16'($signed($urandom_range(0, 64)) - 32);
      2: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  dir_row_t dir_rows[$];

  initial begin
    logic [15:0] s[6];
    logic [itf_pkg::DT_W-1:0] dt;
    logic [itf_pkg::ALPHA_W-1:0] alpha_pick;
    int mode;
    gyro_scale_m = itf_pkg::SCALE_RST;
    blend_alpha_m = itf_pkg::ALPHA_RST;
    roll_est = 0;
    pitch_est = 0;

    dir_rows = '{
      '{CFG_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, '0},
      '{CFG_NONE, 0, 0, 0, 16384, 0, 0, 0, 0, 10000, 1'b0, '0},
      '{CFG_NONE, 0, 0, 0, -16384, 0, 0, 0, 0, 10000, 1'b0, '0},
      '{CFG_NONE, 0, 0, 32767, 0, 0, 0, 0, 0, 10000, 1'b0, '0},
      '{CFG_NONE, 0, 0, -32768, 0, 0, 0, 0, 0, 10000, 1'b0, '0},
      '{CFG_NONE, 0, 0, 0, 0, 16384, 100, -100, 7, 10000, 1'b0, '0},
      '{CFG_NONE, 0, 0, -32768, -32768, -32768, 32767, 32767, 32767, 20'hfffff, 1'b0, '0},
      '{CFG_NONE, 0, 0, 32767, 32767, 32767, -32768, -32768, -32768, 20'hfffff, 1'b0, '0},
      '{CFG_BOTH, 65535, 65536, 100, 200, 300, 32767, -32768, -32768, 0, 1'b0, '0},
      '{CFG_NONE, 0, 0, 5, -5, 9, 32767, 32767, 32767, 20'hfffff, 1'b0, '0},
      '{CFG_NONE, 0, 0, 5, -5, 9, 32767, 32767, 32767, 20'hfffff, 1'b0, '0},
      '{CFG_NONE, 0, 0, 5, -5, 9, -32768, -32768, -32768, 20'hfffff, 1'b0, '0},
      '{CFG_NONE, 0, 0, 5, -5, 9, -32768, -32768, -32768, 20'hfffff, 1'b0, '0},
      '{CFG_BOTH, 1998, 131071, 0, 1000, 0, 500, 500, 500, 5000, 1'b0, '0},
      '{CFG_BOTH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, '0},
      '{CFG_NONE, 0, 0, 0, 0, 0, 32767, -32768, 1, 20'hfffff, 1'b1, '0},
      '{CFG_NONE, 0, 0, -1, 1, -1, 0, 0, 0, 1, 1'b0, '0},
      '{CFG_BOGUS, 0, 0, 1234, -4321, 999, 321, -321, 17, 8000, 1'b0, '0},
      '{CFG_BOTH, 1998, 62915, 0, 0, -16384, 0, 0, 0, 10000, 1'b0, '0},
      '{CFG_NONE, 0, 0, 16384, 16384, 0, 0, 0, 0, 10000, 1'b0, '0}
    };

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].act != CFG_NONE) begin
        wait_idle();
        if (dir_rows[i].act == CFG_BOTH) begin
          write_reg(itf_pkg::REG_GYRO_SCALE, itf_pkg::ALPHA_W'(dir_rows[i].scale));
          write_reg(itf_pkg::REG_BLEND_ALPHA, dir_rows[i].alpha);
        end else begin
          write_reg(REG_UNUSED, 17'h1abcd);
          write_reg(REG_UNUSED - 2'd1, 17'h00001);
        end
      end
      send_sample(pack_sample(dir_rows[i].ax, dir_rows[i].ay, dir_rows[i].az,
                              dir_rows[i].gx, dir_rows[i].gy, dir_rows[i].gz,
                              dir_rows[i].dt),
                  dir_rows[i].typed, dir_rows[i].exp_word);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(itf_pkg::REG_GYRO_SCALE, itf_pkg::ALPHA_W'(itf_pkg::SCALE_RST));
          write_reg(itf_pkg::REG_BLEND_ALPHA, itf_pkg::ALPHA_W'(itf_pkg::ALPHA_RST));
        end
        1: begin
          write_reg(itf_pkg::REG_GYRO_SCALE, 17'd65535);
          write_reg(itf_pkg::REG_BLEND_ALPHA, 17'd0);
        end
        2: begin
          write_reg(itf_pkg::REG_GYRO_SCALE, 17'd0);
          write_reg(itf_pkg::REG_BLEND_ALPHA, 17'd65536);
        end
        default: begin
          write_reg(itf_pkg::REG_GYRO_SCALE, itf_pkg::ALPHA_W'($urandom_range(0, 65535)));
          alpha_pick = ($urandom_range(0, 3) == 0) ? 17'h1ffff
                                                   : itf_pkg::ALPHA_W'($urandom_range(0, 65536));
          write_reg(itf_pkg::REG_BLEND_ALPHA, alpha_pick);
        end
      endcase
      if (ph == 1) long_hold = 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        for (int a = 0; a < 6; a++) begin
          mode = $urandom_range(0, 11);
          s[a] = rand_axis(mode < 4 ? mode : 3);
        end
        dt = ($urandom_range(0, 3) == 0) ? itf_pkg::DT_W'($urandom)
                                         : itf_pkg::DT_W'($urandom_range(0, 20000));
        send_sample(pack_sample(s[0], s[1], s[2], s[3], s[4], s[5], dt), 1'b0, '0);
      end
    end

    wait_idle();
    $display("tb: %0d samples sent, %0d results checked over %0d register settings",
             n_sent, n_checked, RANDOM_PHASES + 4);
    $display("tb: covered zero and full-scale axes, rate and angle saturation, long stalls");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/itf_pkg.sv
rtl/itf_tilt.sv
rtl/itf_cdiv.sv
rtl/itf_datapath.sv
rtl/itf_ctrl.sv
rtl/imu_complementary_tilt_filter_unit.sv
dv/imu_complementary_tilt_filter_unit_tb.sv
